// ===== design/ppvd_pkg.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector package
// Shared widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package ppvd_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 12;
	localparam int TIME_BITS   = 32;
	localparam int WIN_BITS    = 16;
	localparam int VEL_BITS    = 7;
	localparam int CFG_BITS    = 16;
	localparam int IDX_BITS    = 2;

	// The scaled numerator (peak - threshold) * 126 needs seven extra bits.
	localparam int NUM_BITS = SAMPLE_BITS + 7;
	localparam int CNT_BITS = $clog2(NUM_BITS);

	// Register reset values.
	localparam logic [SAMPLE_BITS-1:0] THR_RESET  = SAMPLE_BITS'(400);
	localparam logic [SAMPLE_BITS-1:0] FULL_RESET = SAMPLE_BITS'(4095);
	localparam logic [WIN_BITS-1:0]    SCAN_RESET = WIN_BITS'(10);
	localparam logic [WIN_BITS-1:0]    MASK_RESET = WIN_BITS'(50);

	// Velocity limits.
	localparam logic [VEL_BITS-1:0] VEL_MIN = VEL_BITS'(1);
	localparam logic [VEL_BITS-1:0] VEL_MAX = VEL_BITS'(127);

	// Configuration register indexes.
	typedef enum logic [IDX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_FULL      = 2'd1,
		REG_SCAN_WIN  = 2'd2,
		REG_MASK_WIN  = 2'd3
	} ppvd_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} ppvd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic eval;
		logic div_step;
		logic finish;
		logic load_out;
	} ppvd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic direct;
		logic div_done;
	} ppvd_status_t;

endpackage

// ===== design/ppvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector controller
// Sequences capture, evaluation, the iterative divide and the output transfer.
// ----------------------------------------------------------------------------
module ppvd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ppvd_pkg::ppvd_status_t status,
	output ppvd_pkg::ppvd_cmd_t    cmd
);
	import ppvd_pkg::*;

	ppvd_state_t state_q;
	ppvd_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	// The output register may be loaded when empty or when its transfer completes now.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (!status.hit) begin
					state_d = ST_IDLE;
				end else if (status.direct) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ppvd_datapath.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector datapath
// Configuration registers, scan and mask state, and a restoring divider.
// ----------------------------------------------------------------------------
module ppvd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ppvd_pkg::IDX_BITS-1:0]         cfg_index,
	input  logic [ppvd_pkg::CFG_BITS-1:0]         cfg_data,
	input  logic [ppvd_pkg::SAMPLE_BITS-1:0]      sample,
	input  logic [ppvd_pkg::TIME_BITS-1:0]        now_ms,
	output logic [ppvd_pkg::VEL_BITS-1:0]         velocity,
	input  ppvd_pkg::ppvd_cmd_t                   cmd,
	output ppvd_pkg::ppvd_status_t                status
);
	import ppvd_pkg::*;

	// Configuration registers.
	logic [SAMPLE_BITS-1:0] thr_q;
	logic [SAMPLE_BITS-1:0] full_q;
	logic [WIN_BITS-1:0]    scan_win_q;
	logic [WIN_BITS-1:0]    mask_win_q;

	// Detector state.
	logic                   scanning_q;
	logic                   masking_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [TIME_BITS-1:0]   scan_start_q;
	logic [TIME_BITS-1:0]   mask_end_q;

	// Captured item and divider registers.
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [SAMPLE_BITS-1:0] span_q;
	logic [NUM_BITS-1:0]    num_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [VEL_BITS-1:0]    fin_q;
	logic [VEL_BITS-1:0]    velocity_q;

	// Evaluation terms.
	logic                   released;
	logic                   active;
	logic                   trigger;
	logic [SAMPLE_BITS-1:0] new_peak;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   hit;
	logic                   full_low;
	logic                   peak_low;
	logic [SAMPLE_BITS-1:0] diff;
	logic [NUM_BITS-1:0]    scaled;

	// Divider step terms.
	logic [SAMPLE_BITS:0]   rem_shift;
	logic                   q_bit;
	logic [SAMPLE_BITS:0]   rem_sub;

	// Masking release, scan trigger and scan elapsed tests.
	assign released = !masking_q || (now_q > mask_end_q);
	assign active   = released;
	assign trigger  = active && !scanning_q && (sample_q > thr_q);
	assign new_peak = (sample_q > peak_q) ? sample_q : peak_q;
	assign elapsed  = now_q - scan_start_q;
	assign hit      = active && scanning_q && (elapsed >= TIME_BITS'(scan_win_q));

	// Special cases that bypass the divider.
	assign full_low = (full_q <= thr_q);
	assign peak_low = (new_peak <= thr_q);
	assign diff     = new_peak - thr_q;
	assign scaled   = (NUM_BITS'(diff) << 7) - (NUM_BITS'(diff) << 1);

	assign status.hit      = hit;
	assign status.direct   = full_low || peak_low;
	assign status.div_done = (cnt_q == CNT_BITS'(NUM_BITS - 1));

	// One restoring division step.
	assign rem_shift = {rem_q, num_q[NUM_BITS-1]};
	assign rem_sub   = rem_shift - {1'b0, span_q};
	assign q_bit     = (rem_shift >= {1'b0, span_q});

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			full_q     <= FULL_RESET;
			scan_win_q <= SCAN_RESET;
			mask_win_q <= MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q      <= cfg_data[SAMPLE_BITS-1:0];
				REG_FULL:      full_q     <= cfg_data[SAMPLE_BITS-1:0];
				REG_SCAN_WIN:  scan_win_q <= cfg_data[WIN_BITS-1:0];
				REG_MASK_WIN:  mask_win_q <= cfg_data[WIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Detector state update on evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q   <= 1'b0;
			masking_q    <= 1'b0;
			peak_q       <= '0;
			scan_start_q <= '0;
			mask_end_q   <= '0;
		end else if (cmd.eval && active) begin
			masking_q <= 1'b0;
			if (trigger) begin
				scanning_q   <= 1'b1;
				scan_start_q <= now_q;
				peak_q       <= sample_q;
			end else if (scanning_q) begin
				peak_q <= new_peak;
				if (hit) begin
					scanning_q <= 1'b0;
					masking_q  <= 1'b1;
					mask_end_q <= now_q + TIME_BITS'(mask_win_q);
				end
			end
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
			now_q    <= now_ms;
		end
	end

	// Divider: set up on evaluation, then one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			span_q <= full_q - thr_q;
			num_q  <= scaled;
			rem_q  <= '0;
			cnt_q  <= '0;
			fin_q  <= full_low ? VEL_MAX : VEL_MIN;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_BITS-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
			cnt_q <= cnt_q + CNT_BITS'(1);
		end else if (cmd.finish) begin
			// Quotient plus one, clamped to the top velocity.
			fin_q <= (num_q >= NUM_BITS'(126)) ? VEL_MAX : (num_q[VEL_BITS-1:0] + VEL_MIN);
		end
	end

	// Output data register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			velocity_q <= fin_q;
		end
	end

	assign velocity = velocity_q;

endmodule

// ===== design/piezo_peak_velocity_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector
// Drum trigger: scans for the peak after a threshold crossing, maps it to a
// velocity of 1 to 127 and then masks further hits for a set time.
// ----------------------------------------------------------------------------
//  Channel | Signals                             | Transfer
//  --------+-------------------------------------+----------------------------
//  input   | in_valid, in_ready, sample, now_ms  | in_valid and in_ready high
//  output  | out_valid, out_ready, velocity      | out_valid and out_ready high
//  config  | cfg_we, cfg_index, cfg_data         | cfg_we high, no wait
//
// An item without a result passes only through capture and evaluation; an
// item with a velocity also runs the one-bit-per-cycle restoring divider (19
// steps), then the finishing and output load states. Special-case velocities
// skip the divider and the finishing state. Reset is asynchronous and
// restores the register defaults. One output register lets the next item enter
// while a velocity waits; a second velocity then holds the input until the
// first one is taken.
module piezo_peak_velocity_detector_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppvd_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [ppvd_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ppvd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [ppvd_pkg::TIME_BITS-1:0]   now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ppvd_pkg::VEL_BITS-1:0]    velocity
);
	import ppvd_pkg::*;

	ppvd_cmd_t    cmd;
	ppvd_status_t status;

	// Sequencer.
	ppvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Registers, state and divider.
	ppvd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample),
		.now_ms   (now_ms),
		.velocity (velocity),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== design/ppvd_checker.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ppvd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ppvd_pkg::VEL_BITS-1:0]    velocity
);
	import ppvd_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(velocity))
		else $error("stalled velocity changed or dropped");

	// A delivered velocity is never zero.
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> velocity != '0)
		else $error("velocity out of range");

	// An accepted item keeps the input side busy for the evaluation cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again during evaluation");

	// A new result appears only while the input side was busy.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

endmodule

bind piezo_peak_velocity_detector_unit ppvd_checker u_ppvd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.velocity (velocity)
);

// ===== test/tb_piezo_peak_velocity_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Piezo peak velocity detector testbench
// Sends timestamped samples through the valid/ready input, mirrors the
// idle/scan/mask behavior and the velocity map in a local predictor, and
// compares every velocity transfer against the oldest pending expectation.
// Directed cases cover threshold edges, the clamps, zero windows, counter
// wrap and one long receiver hold-off; random phases then drive strike
// sequences under several settings, with or without random idling on each side.
// ----------------------------------------------------------------------------
module tb_piezo_peak_velocity_detector_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import ppvd_pkg::*;

	localparam int CYCLE_LIMIT    = 500_000;
	localparam int DRAIN_TAIL     = 30;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_SAMPLES  = 120;
	localparam int SQUEEZE_ITEMS  = 40;

	// Clock, reset and block inputs, all known from time zero.
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [IDX_BITS-1:0]    cfg_index = '0;
	logic [CFG_BITS-1:0]    cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sample    = '0;
	logic [TIME_BITS-1:0]   now_ms    = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VEL_BITS-1:0]    velocity;

	// Predictor copy of the registers and of the detector state.
	logic [SAMPLE_BITS-1:0] thr_q      = THR_RESET;
	logic [SAMPLE_BITS-1:0] full_q     = FULL_RESET;
	logic [WIN_BITS-1:0]    scan_win_q = SCAN_RESET;
	logic [WIN_BITS-1:0]    mask_win_q = MASK_RESET;
	logic                   scan_on    = 1'b0;
	logic                   mask_on    = 1'b0;
	logic [SAMPLE_BITS-1:0] peak_q     = '0;
	logic [TIME_BITS-1:0]   scan_t0    = '0;
	logic [TIME_BITS-1:0]   mask_until = '0;

	// Velocities still owed by the block, oldest first.
	logic [VEL_BITS-1:0] pending_velocity[$];
	logic [VEL_BITS-1:0] want;

	// Traffic shaping controls shared with the sender and receiver.
	bit                 tx_burst    = 1'b0;
	bit                 rx_fast     = 1'b0;
	int                 rx_wait     = 0;
	int                 rx_hold_req = 0;
	logic [TIME_BITS-1:0] clock_ms  = '0;

	int errors       = 0;
	int samples_sent = 0;
	int hits_seen    = 0;
	int reg_writes   = 0;
	int cycle_count  = 0;

	piezo_peak_velocity_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.velocity  (velocity)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d velocities outstanding",
				$time, cycle_count, pending_velocity.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Velocity map: linear between threshold and full scale, clamped to 1..127.
	function automatic logic [VEL_BITS-1:0] strike_velocity(logic [SAMPLE_BITS-1:0] pk);
		int q;
		if (full_q <= thr_q)
			return VEL_MAX;
		if (pk <= thr_q)
			return VEL_MIN;
		q = (int'(pk) - int'(thr_q)) * 126 / (int'(full_q) - int'(thr_q)) + 1;
		if (q > int'(VEL_MAX))
			q = int'(VEL_MAX);
		return VEL_BITS'(q);
	endfunction

	// Advance the predicted detector by one accepted sample.
	function automatic void track_sample(logic [SAMPLE_BITS-1:0] s, logic [TIME_BITS-1:0] t);
		logic [TIME_BITS-1:0] elapsed;
		if (mask_on) begin
			// The mask end is a plain unsigned compare, so a wrapped end releases early.
			if (t > mask_until)
				mask_on = 1'b0;
			else
				return;
		end
		if (!scan_on) begin
			if (s > thr_q) begin
				scan_on = 1'b1;
				scan_t0 = t;
				peak_q  = s;
			end
			return;
		end
		if (s > peak_q)
			peak_q = s;
		// Elapsed time is taken modulo the counter width, so it survives wrap.
		elapsed = t - scan_t0;
		if (elapsed >= TIME_BITS'(scan_win_q)) begin
			pending_velocity.push_back(strike_velocity(peak_q));
			scan_on    = 1'b0;
			mask_on    = 1'b1;
			mask_until = t + TIME_BITS'(mask_win_q);
		end
	endfunction

	// Scoreboard: check velocity transfers, then predict from sample transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				hits_seen++;
				if (pending_velocity.size() == 0) begin
					errors++;
					$display("%0t: velocity transfer with none expected, expected none, got %0d",
						$time, velocity);
				end else begin
					want = pending_velocity.pop_front();
					if (velocity !== want) begin
						errors++;
						$display("%0t: velocity mismatch, expected %0d, got %0d",
							$time, want, velocity);
					end
				end
			end
			if (in_valid && in_ready) begin
				samples_sent++;
				track_sample(sample, now_ms);
			end
		end
	end

	// Receiver: after each transfer, hold ready low for a drawn number of cycles.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			rx_wait = rx_fast ? 0 : $urandom_range(0, 9);
	end

	// Receiver ready drive, including the long hold-off counted here.
	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_wait     = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one sample after a drawn gap; returns at the edge of its transfer.
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		now_ms   <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering, wait for every owed velocity, then let the block go quiet.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_velocity.size() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	// Register write; only called once the block has settled.
	task automatic write_reg(input ppvd_reg_t idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_writes++;
		case (idx)
			REG_THRESHOLD: thr_q      = val[SAMPLE_BITS-1:0];
			REG_FULL:      full_q     = val[SAMPLE_BITS-1:0];
			REG_SCAN_WIN:  scan_win_q = val[WIN_BITS-1:0];
			REG_MASK_WIN:  mask_win_q = val[WIN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] full,
			input logic [CFG_BITS-1:0] scan, input logic [CFG_BITS-1:0] mask);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_FULL, full);
		write_reg(REG_SCAN_WIN, scan);
		write_reg(REG_MASK_WIN, mask);
	endtask

	// Reset register values: threshold edge, full-scale peak and mask boundary.
	task automatic test_default_registers();
		push_sample(12'd400, 32'd100);
		push_sample(12'd401, 32'd100);
		push_sample(12'd4095, 32'd105);
		push_sample(12'd0, 32'd110);
		push_sample(12'd4095, 32'd160);
		push_sample(12'd4095, 32'd161);
		push_sample(12'd500, 32'd170);
		push_sample(12'd0, 32'd171);
		settle();
	endtask

	// Velocity clamps, zero windows, degenerate full scale and a raised threshold.
	task automatic test_velocity_map();
		// Upper data bits beyond the register width must be dropped.
		write_all(16'hF000, 16'd4095, 16'd0, 16'd0);
		push_sample(12'd1, 32'd1000);
		push_sample(12'd0, 32'd1000);
		push_sample(12'd4095, 32'd1001);
		push_sample(12'd0, 32'd1001);
		settle();
		write_reg(REG_THRESHOLD, 16'd200);
		write_reg(REG_FULL, 16'd200);
		push_sample(12'd201, 32'd2000);
		push_sample(12'd0, 32'd2000);
		settle();
		write_reg(REG_THRESHOLD, 16'd100);
		write_reg(REG_FULL, 16'd4095);
		write_reg(REG_SCAN_WIN, 16'd5);
		push_sample(12'd150, 32'd3000);
		settle();
		// The peak now sits below the threshold, so the velocity floors at one.
		write_reg(REG_THRESHOLD, 16'd3000);
		push_sample(12'd0, 32'd3005);
		settle();
	endtask

	// Scan across the counter wrap, a wrapped mask end and the widest windows.
	task automatic test_counter_wrap();
		write_all(16'd100, 16'd4095, 16'd10, 16'd50);
		push_sample(12'd2000, 32'hFFFF_FFFA);
		push_sample(12'd3000, 32'h0000_0003);
		push_sample(12'd0, 32'h0000_0004);
		settle();
		write_reg(REG_SCAN_WIN, 16'd0);
		write_reg(REG_MASK_WIN, 16'hFFFF);
		push_sample(12'd4095, 32'h0000_0040);
		push_sample(12'd0, 32'hFFFF_FFF0);
		push_sample(12'd4095, 32'hFFFF_FFF1);
		settle();
		write_reg(REG_SCAN_WIN, 16'hFFFF);
		push_sample(12'd0, 32'h0000_FFF0);
		settle();
	endtask

	// Receiver holds off while the sender streams strikes, so the input stalls.
	task automatic test_output_backpressure();
		int k;
		write_all(16'd100, 16'd4095, 16'd0, 16'd0);
		tx_burst = 1'b1;
		@(posedge clk);
		rx_hold_req = HOLD_CYCLES;
		clock_ms = 32'd50_000;
		for (k = 0; k < SQUEEZE_ITEMS; k++) begin
			clock_ms = clock_ms + 1;
			push_sample(SAMPLE_BITS'($urandom_range(101, 4095)), clock_ms);
		end
		tx_burst = 1'b0;
		settle();
	endtask

	// Random strike sequences with noise and time jumps under several settings.
	task automatic test_random_traffic();
		int phase;
		int k;
		int step_max;
		logic [CFG_BITS-1:0] thr;
		logic [CFG_BITS-1:0] full;
		logic [CFG_BITS-1:0] scan;
		logic [CFG_BITS-1:0] mask;
		logic [SAMPLE_BITS-1:0] s;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					thr  = CFG_BITS'($urandom_range(50, 1000));
					full = CFG_BITS'($urandom_range(int'(thr), 4095));
					scan = CFG_BITS'($urandom_range(0, 8));
					mask = CFG_BITS'($urandom_range(0, 20));
					step_max = 3;
					tx_burst = 1'b0;
					rx_fast  = 1'b0;
				end
				1: begin
					// Widest span with zero windows and no idling on either side.
					thr  = 16'd0;
					full = 16'd4095;
					scan = 16'd0;
					mask = 16'd0;
					step_max = 2;
					tx_burst = 1'b1;
					rx_fast  = 1'b1;
				end
				2: begin
					// Full scale at or under the threshold; junk in the upper data bits.
					thr  = CFG_BITS'($urandom_range(2000, 4095));
					full = CFG_BITS'($urandom_range(0, int'(thr)));
					thr[CFG_BITS-1:SAMPLE_BITS]  = 4'($urandom_range(0, 15));
					full[CFG_BITS-1:SAMPLE_BITS] = 4'($urandom_range(0, 15));
					scan = CFG_BITS'($urandom_range(1, 5));
					mask = CFG_BITS'($urandom_range(1, 10));
					step_max = 3;
					tx_burst = 1'b0;
					rx_fast  = 1'b1;
				end
				3: begin
					// Narrowest span, widest windows, starting just short of the wrap.
					thr  = 16'd4094;
					full = 16'd4095;
					scan = 16'hFFFF;
					mask = 16'hFFFF;
					step_max = 30_000;
					clock_ms = 32'hFFFF_0000;
					tx_burst = 1'b1;
					rx_fast  = 1'b0;
				end
				default: begin
					thr  = CFG_BITS'($urandom_range(0, 65535));
					full = CFG_BITS'($urandom_range(0, 65535));
					scan = CFG_BITS'($urandom_range(0, 65535) >> $urandom_range(0, 15));
					mask = CFG_BITS'($urandom_range(0, 65535) >> $urandom_range(0, 15));
					step_max = int'(scan >> 2) + 3;
					tx_burst = 1'b0;
					rx_fast  = 1'b0;
				end
			endcase
			write_all(thr, full, scan, mask);
			for (k = 0; k < PHASE_SAMPLES; k++) begin
				if ($urandom_range(0, 99) < 8) begin
					// Noise: a random timestamp and an arbitrary level.
					clock_ms = $urandom();
					s = SAMPLE_BITS'($urandom_range(0, 4095));
				end else begin
					clock_ms = clock_ms + TIME_BITS'($urandom_range(0, step_max));
					if ($urandom_range(0, 99) < 30)
						s = SAMPLE_BITS'($urandom_range(int'(thr_q) + 1, 4095));
					else
						s = SAMPLE_BITS'($urandom_range(0, int'(thr_q)));
				end
				push_sample(s, clock_ms);
			end
			settle();
		end
		tx_burst = 1'b0;
		rx_fast  = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_registers();
		test_velocity_map();
		test_counter_wrap();
		test_output_backpressure();
		test_random_traffic();
		settle();

		$display("Run covered %0d sample transfers, %0d velocity transfers, %0d register writes,",
			samples_sent, hits_seen, reg_writes);
		$display("including clamps, zero and widest windows, counter wrap and a receiver hold-off.");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches found", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
